// ===== design/fbpa_pkg.sv =====
package fbpa_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = 32;
  localparam int LOG2_W     = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LOG2_W-1:0] LOG2_MIN = LOG2_W'(2);
  localparam logic [LOG2_W-1:0] LOG2_MAX = LOG2_W'(16);

  // Result status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_BOUNDS = 3'd2;
  localparam logic [2:0] ST_ALIGN  = 3'd3;
  localparam logic [2:0] ST_NONE   = 3'd4;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  used_blocks;
  } rsp_t;

  // One entry of the free-list link store.
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] next_idx;
  } link_t;

  localparam int LINK_W = $bits(link_t);

endpackage

// ===== design/fbpa_link_ram.sv =====
module fbpa_link_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/fixed_block_pool_allocator.sv =====
// Fixed-size block pool allocator. Each request on the in_ channel (allocate
// or free) produces exactly one result transfer on the out_ channel carrying
// a status, the allocated byte address (zero unless an allocate succeeded),
// and the number of blocks in use afterwards. Allocation pops the most
// recently freed block first and otherwise hands out never-used blocks in
// ascending order. Accepting a request in the idle state launches the read of
// the free-list head's link from the link RAM; the execute state then uses
// that registered read data, updates the list and loads the result register,
// waiting while an earlier result is not yet drained. A new request is
// accepted while an earlier result still waits in the output register. The
// link RAM needs no clearing pass after reset: an entry is always written by
// a free before any allocate reads it. Writing any of the three configuration
// registers returns the pool to all-free; the user must write configuration
// only while the block is idle, which the block itself does not enforce.
module fixed_block_pool_allocator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  fbpa_pkg::req_t                        in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output fbpa_pkg::rsp_t                        out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]           cfg_data
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers as written.
  logic [fbpa_pkg::ADDR_W-1:0] pool_base_r, pool_base_nxt;
  logic [fbpa_pkg::LOG2_W-1:0] log2_r, log2_nxt;
  logic [fbpa_pkg::CNT_W-1:0]  count_r, count_nxt;

  // Pool state outside the link RAM.
  logic [fbpa_pkg::IDX_W-1:0]  head_r, head_nxt;
  logic                        present_r, present_nxt;
  logic [fbpa_pkg::CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [fbpa_pkg::CNT_W-1:0]  in_use_r, in_use_nxt;

  // Request captured at accept; the offset is formed in the accept cycle.
  logic                        kind_r, kind_nxt;
  logic [fbpa_pkg::ADDR_W-1:0] off_r, off_nxt;

  logic                        out_valid_r, out_valid_nxt;
  fbpa_pkg::rsp_t              out_data_r, out_data_nxt;

  logic                        in_xfer, cfg_xfer, cfg_hit, finish;
  logic [fbpa_pkg::LOG2_W-1:0] eff_log2;
  logic [fbpa_pkg::CNT_W-1:0]  eff_count;
  logic [fbpa_pkg::ADDR_W-1:0] span, align_mask;
  logic [fbpa_pkg::IDX_W-1:0]  alloc_idx;
  fbpa_pkg::link_t             link_rd, link_wr;
  logic [fbpa_pkg::LINK_W-1:0] link_rd_raw;
  logic                        link_we;
  logic [fbpa_pkg::IDX_W-1:0]  link_waddr;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_xfer  = in_valid && in_ready;
  assign cfg_xfer = cfg_valid && cfg_ready;
  assign cfg_hit  = cfg_xfer && (cfg_index == fbpa_pkg::CFG_POOL_BASE ||
                                 cfg_index == fbpa_pkg::CFG_BLOCK_LOG2 ||
                                 cfg_index == fbpa_pkg::CFG_BLOCK_COUNT);

  // The result register is free when empty or being drained this cycle.
  assign finish = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // Effective block size and count, clamped into their legal ranges.
  always_comb begin
    if (log2_r < fbpa_pkg::LOG2_MIN) begin
      eff_log2 = fbpa_pkg::LOG2_MIN;
    end else if (log2_r > fbpa_pkg::LOG2_MAX) begin
      eff_log2 = fbpa_pkg::LOG2_MAX;
    end else begin
      eff_log2 = log2_r;
    end
    if (count_r > fbpa_pkg::CNT_W'(fbpa_pkg::NUM_BLOCKS)) begin
      eff_count = fbpa_pkg::CNT_W'(fbpa_pkg::NUM_BLOCKS);
    end else begin
      eff_count = count_r;
    end
  end

  assign span       = fbpa_pkg::ADDR_W'(eff_count) << eff_log2;
  assign align_mask = (fbpa_pkg::ADDR_W'(1) << eff_log2) - fbpa_pkg::ADDR_W'(1);

  // The head's link is read on every accept; only an allocate uses it.
  // A free that changes the head writes the RAM in its finishing cycle, so
  // the next request's read always sees the written entry.
  fbpa_link_ram #(
    .DEPTH (fbpa_pkg::NUM_BLOCKS),
    .WIDTH (fbpa_pkg::LINK_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wr),
    .rd_en   (in_xfer),
    .rd_addr (head_r),
    .rd_data (link_rd_raw)
  );

  assign link_rd = fbpa_pkg::link_t'(link_rd_raw);

  always_comb begin
    state_nxt     = state_r;
    pool_base_nxt = pool_base_r;
    log2_nxt      = log2_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    present_nxt   = present_r;
    fresh_nxt     = fresh_r;
    in_use_nxt    = in_use_r;
    kind_nxt      = kind_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    link_we       = 1'b0;
    link_waddr    = fbpa_pkg::IDX_W'((off_r >> eff_log2));
    link_wr.last     = !present_r;
    link_wr.next_idx = present_r ? head_r : '0;
    alloc_idx     = head_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          kind_nxt  = in_data.kind;
          off_nxt   = in_data.free_address - pool_base_r;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (finish) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = fbpa_pkg::ST_OK;
          out_data_nxt.block_address = '0;
          state_nxt                  = S_IDLE;
          if (kind_r == fbpa_pkg::KIND_ALLOC) begin
            if (in_use_r < eff_count && present_r) begin
              // Pop the most recently freed block.
              alloc_idx   = head_r;
              present_nxt = !link_rd.last;
              head_nxt    = link_rd.last ? '0 : link_rd.next_idx;
              in_use_nxt  = in_use_r + fbpa_pkg::CNT_W'(1);
            end else if (in_use_r < eff_count && fresh_r < eff_count) begin
              alloc_idx  = fresh_r[fbpa_pkg::IDX_W-1:0];
              fresh_nxt  = fresh_r + fbpa_pkg::CNT_W'(1);
              in_use_nxt = in_use_r + fbpa_pkg::CNT_W'(1);
            end else begin
              out_data_nxt.status = fbpa_pkg::ST_EMPTY;
            end
            if (out_data_nxt.status == fbpa_pkg::ST_OK) begin
              out_data_nxt.block_address =
                pool_base_r + (fbpa_pkg::ADDR_W'(alloc_idx) << eff_log2);
            end
          end else begin
            if (off_r >= span) begin
              out_data_nxt.status = fbpa_pkg::ST_BOUNDS;
            end else if ((off_r & align_mask) != '0) begin
              out_data_nxt.status = fbpa_pkg::ST_ALIGN;
            end else if (in_use_r == '0) begin
              out_data_nxt.status = fbpa_pkg::ST_NONE;
            end else begin
              // Push the block: it links to the old head and becomes the head.
              link_we     = 1'b1;
              head_nxt    = link_waddr;
              present_nxt = 1'b1;
              in_use_nxt  = in_use_r - fbpa_pkg::CNT_W'(1);
            end
          end
          out_data_nxt.used_blocks = in_use_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The user must make configuration writes only while idle; the block does not enforce it.
    // A write to one of the three registers returns the pool to all-free.
    if (cfg_xfer) begin
      unique case (cfg_index)
        fbpa_pkg::CFG_POOL_BASE:   pool_base_nxt = cfg_data;
        fbpa_pkg::CFG_BLOCK_LOG2:  log2_nxt  = cfg_data[fbpa_pkg::LOG2_W-1:0];
        fbpa_pkg::CFG_BLOCK_COUNT: count_nxt = cfg_data[fbpa_pkg::CNT_W-1:0];
        default: ;
      endcase
      if (cfg_hit) begin
        head_nxt    = '0;
        present_nxt = 1'b0;
        fresh_nxt   = '0;
        in_use_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pool_base_r <= '0;
      log2_r      <= fbpa_pkg::LOG2_W'(4);
      count_r     <= fbpa_pkg::CNT_W'(fbpa_pkg::NUM_BLOCKS);
      head_r      <= '0;
      present_r   <= 1'b0;
      fresh_r     <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_base_r <= pool_base_nxt;
      log2_r      <= log2_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      present_r   <= present_nxt;
      fresh_r     <= fresh_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    off_r      <= off_nxt;
    out_data_r <= out_data_nxt;
  end

  // The count of blocks in use never exceeds the effective pool size.
  a_in_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_use_r <= eff_count)
    else $error("blocks in use exceed pool size");

  // Fresh blocks are never handed out past the end of the pool.
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= fbpa_pkg::CNT_W'(fbpa_pkg::NUM_BLOCKS))
    else $error("fresh block index beyond pool");

  // Every accepted request moves on to the execute cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_EXEC)
    else $error("accepted request did not execute");

  // A new result only appears right after an execute cycle.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result appeared without a request");

endmodule
